@@ rtl/ekv_pkg.sv @@
// ----------------------------------------------------------------------------
// ekv_pkg
// Shared types, byte codes and defaults for the escaped key/value row parser.
// ----------------------------------------------------------------------------
package ekv_pkg;

  localparam int KEY_CAP_DEF   = 32;
  localparam int VALUE_CAP_DEF = 128;
  localparam int ROW_CAP_DEF   = 32;

  localparam int ROW_LIMIT_W = 6;
  localparam logic [ROW_LIMIT_W-1:0] ROW_LIMIT_RST = 6'd32;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_BSL     = 8'h5C;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef struct packed {
    logic [7:0] blob_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   char_valid;
    logic                   in_value_field;
    logic [7:0]             decoded_char;
    logic                   row_done;
    logic                   blob_done;
    logic                   malformed;
    logic [ROW_LIMIT_W-1:0] rows_parsed;
  } out_item_t;

  // Result of one parse step toward the output register.
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

endpackage

@@ rtl/ekv_stream_if.sv @@
// ----------------------------------------------------------------------------
// ekv_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ekv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/escaped_key_value_row_parser.sv @@
// ----------------------------------------------------------------------------
// escaped_key_value_row_parser
// Decodes a backslash-escaped, tab-separated key/value blob one byte a transfer.
// ----------------------------------------------------------------------------
// Takes one blob byte per cycle while the output keeps up: a byte enters the
// input register, is decoded against the row state and lands in the result
// register; a stalled output holds the byte in the input register. Bytes
// that produce nothing (a raw tab, a backslash, ignored bytes) yield no
// result transfer. A malformed blob sets malformed with rows_parsed zero;
// the consumer drops the rows it stored.
// row_limit must only be written between blobs while the block is idle.
module escaped_key_value_row_parser
  import ekv_pkg::*;
#(
  parameter int KEY_CAP   = KEY_CAP_DEF,
  parameter int VALUE_CAP = VALUE_CAP_DEF,
  parameter int ROW_CAP   = ROW_CAP_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  ekv_stream_if.sink            in_ch,
  ekv_stream_if.source          out_ch,
  input logic                   cfg_wr_en,
  input logic [ROW_LIMIT_W-1:0] cfg_wr_data
);

  logic [ROW_LIMIT_W-1:0] row_limit_r;
  logic                   adv, s1_valid, proc, in_ready, out_valid;
  in_item_t               s1_item;
  step_res_t              res;
  out_item_t              out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_limit_r <= ROW_LIMIT_RST;
    end else if (cfg_wr_en) begin
      row_limit_r <= cfg_wr_data;
    end
  end

  assign proc = s1_valid && adv;

  ekv_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_ch.payload),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ekv_row_fsm #(
    .KEY_CAP   (KEY_CAP),
    .VALUE_CAP (VALUE_CAP),
    .ROW_CAP   (ROW_CAP)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .item      (s1_item),
    .row_limit (row_limit_r),
    .res       (res)
  );

  ekv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

@@ rtl/ekv_in_stage.sv @@
// ----------------------------------------------------------------------------
// ekv_in_stage
// Input register: captures one byte per transfer, releases it on advance.
// ----------------------------------------------------------------------------
module ekv_in_stage
  import ekv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     adv,
  output logic     s1_valid,
  output in_item_t s1_item
);

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;
  logic     in_fire;

  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

@@ rtl/ekv_row_fsm.sv @@
// ----------------------------------------------------------------------------
// ekv_row_fsm
// Row parse state: escape decoding, field lengths, row count, error and limit.
// ----------------------------------------------------------------------------
module ekv_row_fsm
  import ekv_pkg::*;
#(
  parameter int KEY_CAP   = KEY_CAP_DEF,
  parameter int VALUE_CAP = VALUE_CAP_DEF,
  parameter int ROW_CAP   = ROW_CAP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   proc,
  input  in_item_t               item,
  input  logic [ROW_LIMIT_W-1:0] row_limit,
  output step_res_t              res
);

  localparam int KW  = $clog2(KEY_CAP);
  localparam int VW  = $clog2(VALUE_CAP);
  localparam int RCW = (ROW_CAP >= 63) ? ROW_LIMIT_W : $clog2(ROW_CAP + 1);

  logic           value_phase_r, value_phase_nxt;
  logic           escape_pending_r, escape_pending_nxt;
  logic [KW-1:0]  key_length_r, key_length_nxt;
  logic [VW-1:0]  value_length_r, value_length_nxt;
  logic [RCW-1:0] row_count_r, row_count_nxt;
  logic           error_seen_r, error_seen_nxt;
  logic           limit_reached_r, limit_reached_nxt;

  logic       row_start, lim_eff, have, row_ended, newerr, cv, iv, rd;
  logic [7:0] ch, b;

  assign b = item.blob_byte;

  always_comb begin
    value_phase_nxt    = value_phase_r;
    escape_pending_nxt = escape_pending_r;
    key_length_nxt     = key_length_r;
    value_length_nxt   = value_length_r;
    row_count_nxt      = row_count_r;
    have      = 1'b0;
    row_ended = 1'b0;
    newerr    = 1'b0;
    cv        = 1'b0;
    iv        = 1'b0;
    rd        = 1'b0;
    ch        = 8'h00;

    row_start = !error_seen_r && !limit_reached_r && !value_phase_r && !escape_pending_r
                && (key_length_r == '0);
    lim_eff = limit_reached_r
              || (row_start && ((ROW_LIMIT_W'(row_count_r) >= row_limit)
                                || (32'(row_count_r) >= 32'(ROW_CAP))));

    if (!error_seen_r && !lim_eff) begin
      if (escape_pending_r) begin
        escape_pending_nxt = 1'b0;
        if (b == CH_BSL) begin
          ch   = CH_BSL;
          have = 1'b1;
        end else if (b == CH_T) begin
          ch   = CH_TAB;
          have = 1'b1;
        end else if (b == CH_N) begin
          ch   = CH_NL;
          have = 1'b1;
        end else begin
          newerr = 1'b1;
        end
      end else if (b == CH_NL) begin
        if (!value_phase_r) begin
          newerr = 1'b1;
        end else begin
          row_count_nxt    = row_count_r + RCW'(1);
          rd               = 1'b1;
          row_ended        = 1'b1;
          value_phase_nxt  = 1'b0;
          key_length_nxt   = '0;
          value_length_nxt = '0;
        end
      end else if (b == CH_TAB && !value_phase_r) begin
        value_phase_nxt = 1'b1;
      end else if (b == CH_BSL) begin
        escape_pending_nxt = 1'b1;
      end else if (b < CTRL_LIMIT) begin
        newerr = 1'b1;
      end else begin
        ch   = b;
        have = 1'b1;
      end

      if (have) begin
        if (!value_phase_r) begin
          if (key_length_r == KW'(KEY_CAP - 1)) begin
            newerr = 1'b1;
          end else begin
            key_length_nxt = key_length_r + KW'(1);
            cv = 1'b1;
          end
        end else begin
          if (value_length_r == VW'(VALUE_CAP - 1)) begin
            newerr = 1'b1;
          end else begin
            value_length_nxt = value_length_r + VW'(1);
            cv = 1'b1;
            iv = 1'b1;
          end
        end
      end

      if (!newerr && item.last_byte && !row_ended) begin
        newerr = 1'b1;
      end
      if (newerr) begin
        cv = 1'b0;
        iv = 1'b0;
        rd = 1'b0;
      end
    end

    error_seen_nxt    = error_seen_r || newerr;
    limit_reached_nxt = lim_eff;

    res.emit                = cv || rd || newerr || item.last_byte;
    res.item.char_valid     = cv;
    res.item.in_value_field = iv;
    res.item.decoded_char   = cv ? ch : 8'h00;
    res.item.row_done       = rd;
    res.item.blob_done      = item.last_byte;
    res.item.malformed      = error_seen_nxt;
    res.item.rows_parsed    = error_seen_nxt ? '0 : ROW_LIMIT_W'(row_count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_phase_r    <= 1'b0;
      escape_pending_r <= 1'b0;
      key_length_r     <= '0;
      value_length_r   <= '0;
      row_count_r      <= '0;
      error_seen_r     <= 1'b0;
      limit_reached_r  <= 1'b0;
    end else if (proc) begin
      if (item.last_byte) begin
        value_phase_r    <= 1'b0;
        escape_pending_r <= 1'b0;
        key_length_r     <= '0;
        value_length_r   <= '0;
        row_count_r      <= '0;
        error_seen_r     <= 1'b0;
        limit_reached_r  <= 1'b0;
      end else begin
        value_phase_r    <= value_phase_nxt;
        escape_pending_r <= escape_pending_nxt;
        key_length_r     <= key_length_nxt;
        value_length_r   <= value_length_nxt;
        row_count_r      <= row_count_nxt;
        error_seen_r     <= error_seen_nxt;
        limit_reached_r  <= limit_reached_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_blob_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item.last_byte |=> (row_count_r == '0) && !error_seen_r && !limit_reached_r
                               && !value_phase_r && !escape_pending_r)
    else $error("parse state not cleared after blob end");

  a_row_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_count_r) <= 32'(ROW_CAP))
    else $error("row count beyond cap");

  a_row_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    proc && res.item.row_done |-> !res.item.char_valid && !res.item.malformed
                                  && res.emit)
    else $error("row completion mixed with character or error");

  a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
    proc && error_seen_r && !item.last_byte |=> error_seen_r)
    else $error("error dropped before blob end");
`endif

endmodule

@@ rtl/ekv_out_stage.sv @@
// ----------------------------------------------------------------------------
// ekv_out_stage
// Result register: holds one result until its transfer completes.
// ----------------------------------------------------------------------------
module ekv_out_stage
  import ekv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      proc,
  input  step_res_t res,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  assign adv = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = proc && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res.emit) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sim/tb_escaped_key_value_row_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escaped_key_value_row_parser
// Streams escaped key/value blobs into the row parser and predicts every
// decoded character, row completion and blob completion in step with the
// input transfers. Covers escapes, each malformed-row case, field overflow,
// the row limit, output backpressure and random blobs under random idling.
// ----------------------------------------------------------------------------
module tb_escaped_key_value_row_parser;
  import ekv_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 150;
  localparam int DRAIN_PAD   = 8;
  localparam int ITEM_TARGET = 1550;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [ROW_LIMIT_W-1:0] cfg_wr_data;

  ekv_stream_if #(.payload_t(in_item_t))  in_ch ();
  ekv_stream_if #(.payload_t(out_item_t)) out_ch ();

  escaped_key_value_row_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Parser state mirror
  logic [ROW_LIMIT_W-1:0] row_limit_m;
  logic                   val_phase_m;
  logic                   esc_m;
  logic [4:0]             key_len_m;
  logic [6:0]             val_len_m;
  logic [5:0]             row_cnt_m;
  logic                   err_m;
  logic                   lim_m;

  out_item_t  decoded_fifo[$];
  logic [7:0] blob_buf[$];
  int         mismatch_count = 0;
  int         items_sent;
  int         idle_cycles = 0;
  bit         src_idle;
  bit         sink_idle;
  bit         hold_req;
  bit         hold_taken;
  int         stall_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic clear_parse_state();
    val_phase_m = 1'b0;
    esc_m       = 1'b0;
    key_len_m   = '0;
    val_len_m   = '0;
    row_cnt_m   = '0;
    err_m       = 1'b0;
    lim_m       = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    out_item_t  r;
    logic       have;
    logic       row_end;
    logic       new_err;
    logic [7:0] ch;
    r       = '0;
    have    = 1'b0;
    row_end = 1'b0;
    new_err = 1'b0;
    ch      = '0;
    if (!err_m && !lim_m && !val_phase_m && !esc_m && key_len_m == 0) begin
      if (row_cnt_m >= row_limit_m || row_cnt_m >= ROW_CAP_DEF) lim_m = 1'b1;
    end
    if (!err_m && !lim_m) begin
      if (esc_m) begin
        esc_m = 1'b0;
        case (b)
          CH_BSL: begin
            ch   = CH_BSL;
            have = 1'b1;
          end
          CH_T: begin
            ch   = CH_TAB;
            have = 1'b1;
          end
          CH_N: begin
            ch   = CH_NL;
            have = 1'b1;
          end
          default: new_err = 1'b1;
        endcase
      end else if (b == CH_NL) begin
        if (!val_phase_m) begin
          new_err = 1'b1;
        end else begin
          row_cnt_m   = row_cnt_m + 1'b1;
          r.row_done  = 1'b1;
          row_end     = 1'b1;
          val_phase_m = 1'b0;
          key_len_m   = '0;
          val_len_m   = '0;
        end
      end else if (b == CH_TAB && !val_phase_m) begin
        val_phase_m = 1'b1;
      end else if (b == CH_BSL) begin
        esc_m = 1'b1;
      end else if (b < CTRL_LIMIT) begin
        new_err = 1'b1;
      end else begin
        ch   = b;
        have = 1'b1;
      end
      if (have) begin
        if (!val_phase_m) begin
          if (int'(key_len_m) + 1 >= KEY_CAP_DEF) begin
            new_err = 1'b1;
          end else begin
            key_len_m    = key_len_m + 1'b1;
            r.char_valid = 1'b1;
          end
        end else begin
          if (int'(val_len_m) + 1 >= VALUE_CAP_DEF) begin
            new_err = 1'b1;
          end else begin
            val_len_m        = val_len_m + 1'b1;
            r.char_valid     = 1'b1;
            r.in_value_field = 1'b1;
          end
        end
      end
      if (!new_err && last && !row_end) new_err = 1'b1;
      if (new_err) begin
        err_m            = 1'b1;
        r.char_valid     = 1'b0;
        r.in_value_field = 1'b0;
        r.row_done       = 1'b0;
      end
    end
    if (r.char_valid || r.row_done || new_err || last) begin
      r.decoded_char = r.char_valid ? ch : 8'h00;
      r.blob_done    = last;
      r.malformed    = err_m;
      r.rows_parsed  = err_m ? '0 : row_cnt_m;
      decoded_fifo.push_back(r);
    end
    if (last) clear_parse_state();
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (decoded_fifo.size() == 0) begin
        flag_mismatch($sformatf("unexpected result char %0d", got.decoded_char));
      end else begin
        want = decoded_fifo.pop_front();
        compare_field("char_valid", got.char_valid, want.char_valid);
        compare_field("in_value_field", got.in_value_field, want.in_value_field);
        compare_field("decoded_char", got.decoded_char, want.decoded_char);
        compare_field("row_done", got.row_done, want.row_done);
        compare_field("blob_done", got.blob_done, want.blob_done);
        compare_field("malformed", got.malformed, want.malformed);
        compare_field("rows_parsed", got.rows_parsed, want.rows_parsed);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 10) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{blob_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, last);
    items_sent++;
  endtask

  task automatic hold_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    hold_input();
    while (decoded_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) blob_buf.push_back(s[i]);
  endtask

  // Send the buffer; mark the final byte as last when the blob ends here
  task automatic send_blob(input bit ends);
    for (int i = 0; i < blob_buf.size(); i++) begin
      send_byte(blob_buf[i], ends && i == blob_buf.size() - 1);
    end
    blob_buf.delete();
  endtask

  task automatic set_row_limit(input logic [ROW_LIMIT_W-1:0] v);
    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    row_limit_m = v;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(32, 255));
    if (b == CH_BSL) b = 8'h5B;
    return b;
  endfunction

  task automatic add_field(input int n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        blob_buf.push_back(CH_BSL);
        case ($urandom_range(0, 2))
          0:       blob_buf.push_back(CH_BSL);
          1:       blob_buf.push_back(CH_T);
          default: blob_buf.push_back(CH_N);
        endcase
      end else begin
        blob_buf.push_back(text_byte());
      end
    end
  endtask

  task automatic send_random_blob();
    int rows;
    int flaw;
    int pos;
    rows = $urandom_range(1, 6);
    flaw = $urandom_range(0, 9);
    for (int r = 0; r < rows; r++) begin
      add_field(($urandom_range(0, 24) == 0) ? $urandom_range(25, 34) : $urandom_range(0, 6));
      blob_buf.push_back(CH_TAB);
      add_field(($urandom_range(0, 49) == 0) ? $urandom_range(120, 130)
                                             : $urandom_range(0, 10));
      blob_buf.push_back(CH_NL);
    end
    pos = $urandom_range(0, blob_buf.size() - 1);
    case (flaw)
      0: blob_buf.insert(pos, 8'($urandom_range(0, 255)));
      1: blob_buf[pos] = 8'($urandom_range(0, 255));
      2: repeat (blob_buf.size() - 1 - pos) void'(blob_buf.pop_back());
      3: blob_buf.push_back(CH_BSL);
      4: blob_buf.insert(pos, 8'($urandom_range(0, 31)));
      default: ;
    endcase
    send_blob(1'b1);
  endtask

  task automatic test_basic_rows();
    blob_buf.push_back(8'h20);
    blob_buf.push_back(8'hFF);
    add_text("\\\\\t\\t\\n~\na\t\n");
    send_blob(1'b1);
  endtask

  task automatic test_malformed_rows();
    add_text("a\\q");
    send_blob(1'b1);
    add_text("\\");
    blob_buf.push_back(8'h01);
    send_blob(1'b1);
    blob_buf.push_back(8'h00);
    add_text("zz");
    send_blob(1'b1);
    add_text("k\n");
    send_blob(1'b1);
    add_text("k\tv\tw\n");
    send_blob(1'b1);
    add_text("a\tb\\");
    send_blob(1'b1);
    add_text("a\tb");
    send_blob(1'b1);
    blob_buf.push_back(8'hFF);
    send_blob(1'b1);
  endtask

  task automatic test_field_overflow();
    repeat (32) blob_buf.push_back(text_byte());
    add_text("\tv\n");
    send_blob(1'b1);
    add_text("k\t");
    repeat (128) blob_buf.push_back(text_byte());
    add_text("\n");
    send_blob(1'b1);
  endtask

  task automatic test_row_limit();
    set_row_limit(6'd0);
    add_text("a\tb\n");
    send_blob(1'b1);
    set_row_limit(6'd1);
    add_text("a\tb\nc\td\ne");
    send_blob(1'b1);
    set_row_limit(6'd63);
    repeat (34) add_text("a\tb\n");
    send_blob(1'b1);
    set_row_limit(ROW_LIMIT_RST);
  endtask

  task automatic test_output_stall();
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (3) begin
      add_field(20);
      blob_buf.push_back(CH_TAB);
      add_field(24);
      blob_buf.push_back(CH_NL);
    end
    send_blob(1'b1);
    src_idle = 1'b1;
  endtask

  task automatic test_sender_pause();
    add_text("key\tval");
    send_blob(1'b0);
    wait_drained();
    add_text("ue\n");
    send_blob(1'b1);
  endtask

  task automatic test_random_blobs();
    logic [ROW_LIMIT_W-1:0] limits[5];
    int                     phase_end;
    limits = '{6'd63, 6'd2, 6'd0, 6'd32, 6'd5};
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_row_limit(ROW_LIMIT_W'($urandom_range(0, 63)));
      end else begin
        set_row_limit(limits[p]);
      end
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (6 - p);
      while (items_sent < phase_end) send_random_blob();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    items_sent     = 0;
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    hold_req       = 1'b0;
    row_limit_m    = ROW_LIMIT_RST;
    clear_parse_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_rows();
    test_malformed_rows();
    test_field_overflow();
    test_row_limit();
    test_output_stall();
    test_sender_pause();
    test_random_blobs();

    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
